// ----- design/wts_pkg.sv -----
// Shared constants, types and register codes for the world-to-screen projection.
package wts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FLOOR_W   = SUM_W - FRAC_BITS;
  localparam int CLIP_W    = ((FLOOR_W > COORD_W) ? FLOOR_W : COORD_W) + 1;
  localparam int NUM_W     = CLIP_W + 1;
  localparam int SIZE_W    = 14;
  localparam int MUL_W     = NUM_W + SIZE_W;
  localparam int DIVIDEND_W = MUL_W + FRAC_BITS;
  localparam int QUO_W     = COORD_W + 1;
  localparam int CMP_W     = DIVIDEND_W + 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CX_XY  = 3'd0,
    REG_CX_ZO  = 3'd1,
    REG_CY_XY  = 3'd2,
    REG_CY_ZO  = 3'd3,
    REG_CW_XY  = 3'd4,
    REG_CW_ZO  = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic neg;
    logic wz;
  } div_ctl_t;

endpackage

// ----- design/wts_row.sv -----
// One row of the view-projection matrix: three products, floored sum plus offset.
module wts_row (
  input  logic                              clk_i,
  input  logic signed [wts_pkg::COORD_W-1:0] x_i,
  input  logic signed [wts_pkg::COORD_W-1:0] y_i,
  input  logic signed [wts_pkg::COORD_W-1:0] z_i,
  input  logic        [wts_pkg::CFG_W-1:0]   r_xy_i,
  input  logic        [wts_pkg::CFG_W-1:0]   r_zo_i,
  output logic signed [wts_pkg::CLIP_W-1:0]  clip_o
);
  import wts_pkg::*;

  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;
  logic signed [COORD_W-1:0] off_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   fl;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    px_q  <= PROD_W'($signed(r_xy_i[COORD_W-1:0]))       * PROD_W'(x_i);
    py_q  <= PROD_W'($signed(r_xy_i[CFG_W-1:COORD_W]))   * PROD_W'(y_i);
    pz_q  <= PROD_W'($signed(r_zo_i[COORD_W-1:0]))       * PROD_W'(z_i);
    off_q <= $signed(r_zo_i[CFG_W-1:COORD_W]);
  end

  // stage 2: floor to the fixed-point grid, then offset
  always_comb begin
    sum = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q);
    fl  = sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    clip_o <= CLIP_W'(fl) + CLIP_W'(off_q);
  end

endmodule

// ----- design/wts_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with saturation to 32 bits.
module wts_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  wts_pkg::div_ctl_t                   ctl_i,
  input  logic [wts_pkg::DIVIDEND_W-1:0]      n_i,
  input  logic [wts_pkg::NUM_W-1:0]           d_i,
  output logic                                vld_o,
  output logic                                wz_o,
  output logic signed [wts_pkg::COORD_W-1:0]  res_o
);
  import wts_pkg::*;

  localparam int NSTG = QUO_W + 1;

  logic                  vld_q [NSTG];
  div_ctl_t              ctl_q [NSTG];
  logic                  ovf_q [NSTG];
  logic [DIVIDEND_W-1:0] rem_q [NSTG];
  logic [NUM_W-1:0]      d_q   [NSTG];
  logic [QUO_W-1:0]      quo_q [NSTG];
  logic [QUO_W-1:0]      qf;

  // stage 0: quotient too big for QUO_W bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl_i;
    ovf_q[0] <= CMP_W'(n_i) >= (CMP_W'(d_i) << QUO_W);
    rem_q[0] <= n_i;
    d_q[0]   <= d_i;
    quo_q[0] <= '0;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic [CMP_W-1:0] dsh;
    logic             ge;

    always_comb begin
      dsh = CMP_W'(d_q[k]) << (QUO_W - 1 - k);
      ge  = CMP_W'(rem_q[k]) >= dsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[k+1] <= ctl_q[k];
      ovf_q[k+1] <= ovf_q[k];
      d_q[k+1]   <= d_q[k];
      rem_q[k+1] <= ge ? (rem_q[k] - dsh[DIVIDEND_W-1:0]) : rem_q[k];
      quo_q[k+1] <= quo_q[k] | (ge ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
    end
  end

  assign qf = quo_q[QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    wz_o <= ctl_q[QUO_W].wz;
    priority if (ctl_q[QUO_W].wz) begin
      res_o <= '0;
    end else if (ctl_q[QUO_W].neg) begin
      if (ovf_q[QUO_W] || qf > (QUO_W'(1) << (COORD_W - 1))) begin
        res_o <= {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res_o <= COORD_W'(-qf);
      end
    end else begin
      if (ovf_q[QUO_W] || qf[QUO_W-1:COORD_W-1] != '0) begin
        res_o <= {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        res_o <= COORD_W'(qf);
      end
    end
  end

endmodule

// ----- design/world_to_screen_projection.sv -----
// Top level of the world-to-screen projection pipeline.
//
// Usage:
//  - Items enter on start_i with world_x_i, world_y_i, world_z_i (signed Q16.16).
//    busy_o is held low, so an item is taken on every cycle that start_i is high.
//  - Each item gives one result: done_o pulses for one cycle with screen_x_o,
//    screen_y_o (signed Q16.16 pixels, saturated) and w_is_zero_o.
//  - Throughput is one item per cycle. Most of the depth is in the
//    divider, one quotient bit per stage.
//  - Results leave in order; the receiver cannot stall, so nothing is held.
//  - Matrix rows and viewport size are written on the cfg channel (always
//    ready); write them only while no item is in flight.
//  - Reset clears all valid bits and loads identity-like rows and a
//    1920 x 1080 viewport.
//  - If clip w is zero the item gives zero coordinates and w_is_zero_o high.
module world_to_screen_projection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  output logic                               done_o,
  input  logic signed [wts_pkg::COORD_W-1:0] world_x_i,
  input  logic signed [wts_pkg::COORD_W-1:0] world_y_i,
  input  logic signed [wts_pkg::COORD_W-1:0] world_z_i,
  output logic signed [wts_pkg::COORD_W-1:0] screen_x_o,
  output logic signed [wts_pkg::COORD_W-1:0] screen_y_o,
  output logic                               w_is_zero_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wts_pkg::CFG_W-1:0]          cfg_data_i
);
  import wts_pkg::*;

  localparam int NVLD = 5;

  // configuration registers
  logic [CFG_W-1:0]  cx_xy_q, cx_zo_q, cy_xy_q, cy_zo_q, cw_xy_q, cw_zo_q;
  logic [SIZE_W-1:0] width_q, height_q;

  logic vld_q [NVLD];

  logic signed [CLIP_W-1:0] cx, cy, cw;
  logic signed [NUM_W-1:0]  nx_q, ny_q;
  logic signed [CLIP_W-1:0] cw_q;
  logic [NUM_W-1:0]         mx_q, my_q, den_q, den2_q;
  logic [NUM_W-1:0]         mx, my;
  logic [CLIP_W-1:0]        cw_mag;
  div_ctl_t                 ctlx_q, ctly_q, ctlx2_q, ctly2_q;
  logic [DIVIDEND_W-1:0]    divx_q, divy_q;
  logic                     done_x, done_y, wz_y;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_xy_q  <= CFG_W'(64'h0000_0000_0001_0000);
      cx_zo_q  <= '0;
      cy_xy_q  <= CFG_W'(64'h0001_0000_0000_0000);
      cy_zo_q  <= '0;
      cw_xy_q  <= '0;
      cw_zo_q  <= CFG_W'(64'h0001_0000_0000_0000);
      width_q  <= SIZE_W'(1920);
      height_q <= SIZE_W'(1080);
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CX_XY:  cx_xy_q  <= cfg_data_i;
        REG_CX_ZO:  cx_zo_q  <= cfg_data_i;
        REG_CY_XY:  cy_xy_q  <= cfg_data_i;
        REG_CY_ZO:  cy_zo_q  <= cfg_data_i;
        REG_CW_XY:  cw_xy_q  <= cfg_data_i;
        REG_CW_ZO:  cw_zo_q  <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // valid bits for the front stages: two in the rows, three here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NVLD; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
      for (int i = 1; i < NVLD; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // clip rows, two stages each
  wts_row u_row_x (.clk_i, .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
                   .r_xy_i(cx_xy_q), .r_zo_i(cx_zo_q), .clip_o(cx));
  wts_row u_row_y (.clk_i, .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
                   .r_xy_i(cy_xy_q), .r_zo_i(cy_zo_q), .clip_o(cy));
  wts_row u_row_w (.clk_i, .x_i(world_x_i), .y_i(world_y_i), .z_i(world_z_i),
                   .r_xy_i(cw_xy_q), .r_zo_i(cw_zo_q), .clip_o(cw));

  // stage 3: numerators w+x and w-y, before scaling by W and H
  always_ff @(posedge clk_i) begin
    nx_q <= NUM_W'(cw) + NUM_W'(cx);
    ny_q <= NUM_W'(cw) - NUM_W'(cy);
    cw_q <= cw;
  end

  // stage 4: magnitudes and signs; divisor is 2*|w|
  always_comb begin
    mx     = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
    my     = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
    cw_mag = cw_q[CLIP_W-1] ? CLIP_W'(-cw_q) : CLIP_W'(cw_q);
  end

  always_ff @(posedge clk_i) begin
    mx_q       <= mx;
    my_q       <= my;
    den_q      <= {cw_mag, 1'b0};
    ctlx_q.neg <= nx_q[NUM_W-1] ^ cw_q[CLIP_W-1];
    ctly_q.neg <= ny_q[NUM_W-1] ^ cw_q[CLIP_W-1];
    ctlx_q.wz  <= (cw_q == '0);
    ctly_q.wz  <= (cw_q == '0);
  end

  // stage 5: scale by viewport size, shift to fixed point
  always_ff @(posedge clk_i) begin
    divx_q  <= {MUL_W'(mx_q) * MUL_W'(width_q), {FRAC_BITS{1'b0}}};
    divy_q  <= {MUL_W'(my_q) * MUL_W'(height_q), {FRAC_BITS{1'b0}}};
    den2_q  <= den_q;
    ctlx2_q <= ctlx_q;
    ctly2_q <= ctly_q;
  end

  wts_div u_div_x (
    .clk_i, .rst_ni, .vld_i(vld_q[NVLD-1]), .ctl_i(ctlx2_q), .n_i(divx_q),
    .d_i(den2_q), .vld_o(done_x), .wz_o(w_is_zero_o), .res_o(screen_x_o)
  );

  wts_div u_div_y (
    .clk_i, .rst_ni, .vld_i(vld_q[NVLD-1]), .ctl_i(ctly2_q), .n_i(divy_q),
    .d_i(den2_q), .vld_o(done_y), .wz_o(wz_y), .res_o(screen_y_o)
  );

  assign done_o = done_x & done_y;

`ifndef SYNTHESIS
  a_zero_w_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && w_is_zero_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("zero w item with nonzero coordinates");

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y && (!done_o || wz_y == w_is_zero_o))
    else $error("divider lanes out of step");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##40 done_o)
    else $error("item result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##40 !done_o)
    else $error("result without item");
`endif

endmodule

// ----- tb/sv/tb_world_to_screen_projection.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for world_to_screen_projection: directed and random points against a local projector.
module tb_world_to_screen_projection;
  import wts_pkg::*;

  // One world point in flight, and the screen position it should give
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               wz;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, w_is_zero_o, cfg_ready_o;
  logic signed [31:0] world_x_i = '0, world_y_i = '0, world_z_i = '0;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  world_to_screen_projection dut (.*);

  // Register image kept in step with every write the block takes
  logic [63:0] row_cx_xy, row_cx_zo, row_cy_xy, row_cy_zo, row_cw_xy, row_cw_zo;
  logic [13:0] view_w, view_h;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int unsigned idle_pct = 16;
  int errors = 0;
  int cycles = 0;
  logic busy_s = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Weighted sum of one matrix row: exact products, floored to Q16.16, then offset
  function automatic logic signed [79:0] clip_of(logic [63:0] xy, logic [63:0] zo,
                                                 point_t p);
    logic signed [31:0] wx, wy, wzw, off;
    logic signed [79:0] acc;
    wx = xy[31:0];
    wy = xy[63:32];
    wzw = zo[31:0];
    off = zo[63:32];
    acc = wx * p.x + wy * p.y + wzw * p.z;
    return (acc >>> FRAC_BITS) + off;
  endfunction

  // size * num / (2 * den), truncated toward zero, saturated to 32 bits
  function automatic logic signed [31:0] pixel_of(logic signed [79:0] num,
                                                  logic signed [79:0] den,
                                                  logic [13:0] size);
    logic [127:0] an, ad, q;
    logic neg;
    neg = num[79] ^ den[79];
    an = 128'(num[79] ? -num : num);
    ad = 128'(den[79] ? -den : den);
    q = ((an * size) << FRAC_BITS) / (ad << 1);
    if (neg) return (q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  function automatic pixel_t project(point_t p);
    logic signed [79:0] cx, cy, cw;
    pixel_t r;
    cx = clip_of(row_cx_xy, row_cx_zo, p);
    cy = clip_of(row_cy_xy, row_cy_zo, p);
    cw = clip_of(row_cw_xy, row_cw_zo, p);
    if (cw == 0) begin
      r.sx = '0;
      r.sy = '0;
      r.wz = 1'b1;
    end else begin
      r.sx = pixel_of(cw + cx, cw, view_w);
      r.sy = pixel_of(cw - cy, cw, view_h);
      r.wz = 1'b0;
    end
    return r;
  endfunction

  // Handshake signals sampled mid-cycle so edge ordering never matters
  always @(negedge clk_i) begin
    busy_s <= busy_o;
  end

  // Driver: issues queued points, idling at the current rate
  always @(posedge clk_i) begin
    point_t p;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start_i && !busy_s) begin
        p.x = world_x_i;
        p.y = world_y_i;
        p.z = world_z_i;
        expected_pixels.push_back(project(p));
      end
      if ((!start_i || !busy_s) ) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
          p = pending_points.pop_front();
          start_i <= 1'b1;
          world_x_i <= p.x;
          world_y_i <= p.y;
          world_z_i <= p.z;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result lives for one cycle only, so check it mid-cycle
  always @(negedge clk_i) begin
    pixel_t e;
    if (rst_ni && done_o) begin
      if (expected_pixels.size() == 0) begin
        $error("result with nothing expected: screen_x %0d screen_y %0d",
               screen_x_o, screen_y_o);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (screen_x_o !== e.sx) begin
          $error("screen_x expected %0d got %0d", e.sx, screen_x_o);
          errors++;
        end
        if (screen_y_o !== e.sy) begin
          $error("screen_y expected %0d got %0d", e.sy, screen_y_o);
          errors++;
        end
        if (w_is_zero_o !== e.wz) begin
          $error("w_is_zero expected %0b got %0b", e.wz, w_is_zero_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > 200000) begin
      $display("tb_world_to_screen_projection: done, errors");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    logic ok;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CX_XY:  row_cx_xy = val;
      REG_CX_ZO:  row_cx_zo = val;
      REG_CY_XY:  row_cy_xy = val;
      REG_CY_ZO:  row_cy_zo = val;
      REG_CW_XY:  row_cw_xy = val;
      REG_CW_ZO:  row_cw_zo = val;
      REG_WIDTH:  view_w = val[13:0];
      REG_HEIGHT: view_h = val[13:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4:          return '0;
      default:    return 32'($signed($urandom_range(2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_coord(), rand_coord()};
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_pixels.size() > 0) @(posedge clk_i);
    // block may still be working on nothing; wait out the pipe before reprogramming
    repeat (45) @(posedge clk_i);
  endtask

  initial begin
    // reset image matches the block's load values
    row_cx_xy = 64'd65536;
    row_cx_zo = '0;
    row_cy_xy = 64'd281474976710656;
    row_cy_zo = '0;
    row_cw_xy = '0;
    row_cw_zo = 64'd281474976710656;
    view_w = 14'd1920;
    view_h = 14'd1080;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // phase 0: reset matrix, directed extremes then random
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
    add_point(32'hFFFF_0000, 32'h0001_0000, 32'h0);
    add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    add_point(32'h0000_8000, 32'hFFFF_8000, 32'h1234_5678);
    add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    for (int i = 0; i < 110; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // phase 1: perspective-like, cw = -z, so z of zero hits the zero-w case
    idle_pct = 53;
    write_reg(REG_CX_XY, {32'h0, 32'h0002_0000});
    write_reg(REG_CX_ZO, {32'h0000_4000, 32'h0});
    write_reg(REG_CY_XY, {32'h0001_8000, 32'h0});
    write_reg(REG_CY_ZO, {32'hFFFF_C000, 32'h0});
    write_reg(REG_CW_XY, 64'h0);
    write_reg(REG_CW_ZO, {32'h0, 32'hFFFF_0000});
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd1);
    add_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    add_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    add_point(32'h0, 32'h0, 32'h0000_0001);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 110; i++) begin
      add_point(rand_coord(), rand_coord(), ($urandom_range(7) == 0) ? 32'h0 : rand_coord());
    end
    drain();

    // phase 2: fully random matrix, smallest viewport on x, 8192 pixels on y
    idle_pct = 0;
    write_reg(REG_CX_XY, {$urandom(), $urandom()});
    write_reg(REG_CX_ZO, {$urandom(), $urandom()});
    write_reg(REG_CY_XY, {$urandom(), $urandom()});
    write_reg(REG_CY_ZO, {$urandom(), $urandom()});
    write_reg(REG_CW_XY, {$urandom(), $urandom()});
    write_reg(REG_CW_ZO, {$urandom(), $urandom()});
    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd8192);
    for (int i = 0; i < 110; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // phase 3: moderate random weights, random viewport
    for (int r = 0; r < 6; r++) write_reg(reg_idx_e'(r), rand_pair());
    write_reg(REG_WIDTH, 64'($urandom_range(8192, 1)));
    write_reg(REG_HEIGHT, 64'($urandom_range(8192, 1)));
    for (int i = 0; i < 110; i++) add_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    if (errors == 0) begin
      $display("tb_world_to_screen_projection: done, clean");
    end else begin
      $display("tb_world_to_screen_projection: done, errors");
    end
    $finish;
  end

endmodule
